// File: rtl/lru_writeback_sector_cache_defines.svh
// Assertion macros shared by the sector cache RTL.
`ifndef LRU_WRITEBACK_SECTOR_CACHE_DEFINES_SVH
`define LRU_WRITEBACK_SECTOR_CACHE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define LWSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define LWSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lwsc_pkg.sv
//------------------------------------------------------------------------------
// lwsc_pkg
// Types and constants shared by the sector cache controller.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lwsc_pkg;

    localparam int unsigned SLOT_W = 6;
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_FLUSH = 2'd2,
        REQ_NOP   = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_WB_FAIL  = 2'd1,
        ST_FILL_FAIL = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] sector_addr;
        logic        wb_fails;
        logic        fill_fails;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              wb_issued;
        logic [31:0]       wb_addr;
        logic              fill_issued;
        logic [1:0]        status;
        logic              last;
        logic [31:0]       hit_count;
        logic [31:0]       miss_count;
        logic [31:0]       evict_count;
        logic [31:0]       wb_count;
    } rsp_t;

    typedef enum logic [2:0] {
        BE_IDLE,
        BE_LOOKUP,
        BE_SCAN,
        BE_ACCESS,
        BE_FLUSH,
        BE_DONE
    } be_state_t;

endpackage

`default_nettype wire

// File: rtl/lwsc_front.sv
//------------------------------------------------------------------------------
// lwsc_front
// Request intake: classifies each word and holds it in a two-entry queue.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lwsc_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire lwsc_pkg::req_t push_data,
    output logic                full,
    output logic                empty,
    input  wire logic           pop,
    output lwsc_pkg::req_t      head
);
    import lwsc_pkg::*;

    req_t       q_reg [2];
    logic       rd_reg, rd_next;
    logic       wr_reg, wr_next;
    logic [1:0] cnt_reg, cnt_next;
    req_t       cls;

    // Every request code is defined, so the word passes through as given.
    always_comb
    begin
        cls = push_data;
        if (push_data.req_type == REQ_NOP)
        begin
            cls.req_type = REQ_NOP;
        end
    end

    always_comb
    begin
        rd_next  = rd_reg ^ pop;
        wr_next  = wr_reg ^ push;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= cls;
        end
    end

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = q_reg[rd_reg];

endmodule

`default_nettype wire

// File: rtl/lwsc_back.sv
//------------------------------------------------------------------------------
// lwsc_back
// Execution engine: tag search, victim choice, fills and flush sweep.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lru_writeback_sector_cache_defines.svh"

module lwsc_back #(
    parameter int unsigned NUM_ENTRIES = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           avail,
    input  wire lwsc_pkg::req_t req,
    output logic                take,
    output logic                strobe,
    output lwsc_pkg::rsp_t      result
);
    import lwsc_pkg::*;

    localparam int unsigned IDX_W = $clog2(NUM_ENTRIES);
    localparam int unsigned CNT_W = $clog2(NUM_ENTRIES + 1);

    logic [NUM_ENTRIES-1:0] valid_reg;
    logic [NUM_ENTRIES-1:0] dirty_reg;
    logic [31:0]            tag_mem [NUM_ENTRIES];
    logic [31:0]            age_mem [NUM_ENTRIES];

    be_state_t        state_reg, state_next;
    req_t             cur_reg;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] ent_reg, ent_next;
    logic             inv_reg, inv_next;
    logic [31:0]      old_reg, old_next;
    logic             fst_reg, fst_next;
    logic             any_reg, any_next;
    logic [31:0]      clock_reg;
    logic [31:0]      hits_reg, misses_reg, evict_reg, wbs_reg;
    logic [31:0]      tag_rd_reg, age_rd_reg;
    logic             rd_ok_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             strobe_reg;
    rsp_t             result_reg;
    logic [IDX_W-1:0] idx_lo;
    logic             pend_last;

    assign idx_lo = idx_reg[IDX_W-1:0];

    // Registered read of both stores; the scan reads one entry per cycle.
    always_ff @(posedge clk)
    begin
        tag_rd_reg <= tag_mem[idx_lo];
        age_rd_reg <= age_mem[idx_lo];
        rd_idx_reg <= idx_lo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            rd_ok_reg <= (state_reg == BE_SCAN || state_reg == BE_FLUSH)
                         && (idx_reg < CNT_W'(NUM_ENTRIES));
        end
    end

    assign take = (state_reg == BE_IDLE) && avail;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        ent_next   = ent_reg;
        inv_next   = inv_reg;
        old_next   = old_reg;
        fst_next   = fst_reg;
        any_next   = any_reg;
        pend_last  = 1'b0;
        case (state_reg)
            BE_IDLE:
            begin
                if (avail)
                begin
                    state_next = BE_LOOKUP;
                end
            end
            BE_LOOKUP:
            begin
                idx_next   = '0;
                found_next = 1'b0;
                inv_next   = 1'b0;
                ent_next   = '0;
                old_next   = CNT_MAX;
                fst_next   = 1'b0;
                any_next   = 1'b0;
                case (cur_reg.req_type)
                    REQ_READ, REQ_WRITE: state_next = BE_SCAN;
                    REQ_FLUSH:           state_next = BE_FLUSH;
                    default:             state_next = BE_DONE;
                endcase
            end
            BE_SCAN:
            begin
                if (idx_reg < CNT_W'(NUM_ENTRIES))
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (rd_ok_reg)
                begin
                    if (valid_reg[rd_idx_reg] && tag_rd_reg == cur_reg.sector_addr
                        && !found_next)
                    begin
                        found_next = 1'b1;
                        ent_next   = rd_idx_reg;
                    end
                    else if (!found_reg && !inv_reg)
                    begin
                        if (!valid_reg[rd_idx_reg])
                        begin
                            inv_next = 1'b1;
                            ent_next = rd_idx_reg;
                        end
                        else if (age_rd_reg < old_reg)
                        begin
                            old_next = age_rd_reg;
                            ent_next = rd_idx_reg;
                        end
                    end
                end
                if (!rd_ok_reg && idx_reg == CNT_W'(NUM_ENTRIES))
                begin
                    state_next = BE_ACCESS;
                end
            end
            BE_ACCESS:
            begin
                state_next = BE_IDLE;
            end
            BE_FLUSH:
            begin
                if (idx_reg < CNT_W'(NUM_ENTRIES))
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (rd_ok_reg && valid_reg[rd_idx_reg] && dirty_reg[rd_idx_reg])
                begin
                    any_next = 1'b1;
                    if (cur_reg.wb_fails)
                    begin
                        fst_next = 1'b1;
                    end
                end
                if (!rd_ok_reg && idx_reg == CNT_W'(NUM_ENTRIES))
                begin
                    state_next = BE_IDLE;
                    pend_last  = 1'b1;
                end
            end
            BE_DONE:
            begin
                state_next = BE_IDLE;
            end
            default:
            begin
                state_next = BE_IDLE;
            end
        endcase
    end

    // Dirty entries left above an index, used to mark the final flush word.
    logic [NUM_ENTRIES-1:0] vd;
    logic                   more_above;
    assign vd = valid_reg & dirty_reg;
    always_comb
    begin
        more_above = 1'b0;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            if (i > int'(rd_idx_reg) && vd[i])
            begin
                more_above = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BE_IDLE && avail)
        begin
            cur_reg <= req;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BE_ACCESS && !found_reg
            && !(valid_reg[ent_reg] && dirty_reg[ent_reg] && cur_reg.wb_fails)
            && !cur_reg.fill_fails)
        begin
            tag_mem[ent_reg] <= cur_reg.sector_addr;
        end
        if (state_reg == BE_ACCESS
            && (found_reg
                || (!(valid_reg[ent_reg] && dirty_reg[ent_reg] && cur_reg.wb_fails)
                    && !cur_reg.fill_fails)))
        begin
            age_mem[ent_reg] <= clock_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BE_IDLE;
            idx_reg    <= '0;
            found_reg  <= 1'b0;
            ent_reg    <= '0;
            inv_reg    <= 1'b0;
            old_reg    <= CNT_MAX;
            fst_reg    <= 1'b0;
            any_reg    <= 1'b0;
            valid_reg  <= '0;
            dirty_reg  <= '0;
            clock_reg  <= '0;
            hits_reg   <= '0;
            misses_reg <= '0;
            evict_reg  <= '0;
            wbs_reg    <= '0;
            strobe_reg <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            found_reg  <= found_next;
            ent_reg    <= ent_next;
            inv_reg    <= inv_next;
            old_reg    <= old_next;
            fst_reg    <= fst_next;
            any_reg    <= any_next;
            strobe_reg <= 1'b0;
            result_reg <= '0;
            case (state_reg)
                BE_ACCESS:
                begin
                    strobe_reg       <= 1'b1;
                    result_reg.last  <= 1'b1;
                    result_reg.slot  <= SLOT_W'(ent_reg);
                    result_reg.hit_count   <= hits_reg;
                    result_reg.miss_count  <= misses_reg;
                    result_reg.evict_count <= evict_reg;
                    result_reg.wb_count    <= wbs_reg;
                    if (found_reg)
                    begin
                        result_reg.hit <= 1'b1;
                        clock_reg <= clock_reg + 32'd1;
                        if (cur_reg.req_type == REQ_WRITE)
                        begin
                            dirty_reg[ent_reg] <= 1'b1;
                        end
                        else
                        begin
                            hits_reg <= hits_reg + 32'd1;
                            result_reg.hit_count <= hits_reg + 32'd1;
                        end
                    end
                    else
                    begin
                        misses_reg <= misses_reg + 32'd1;
                        result_reg.miss_count <= misses_reg + 32'd1;
                        if (valid_reg[ent_reg] && dirty_reg[ent_reg])
                        begin
                            wbs_reg <= wbs_reg + 32'd1;
                            result_reg.wb_count  <= wbs_reg + 32'd1;
                            result_reg.wb_issued <= 1'b1;
                            result_reg.wb_addr   <= tag_mem[ent_reg];
                        end
                        if (valid_reg[ent_reg] && dirty_reg[ent_reg] && cur_reg.wb_fails)
                        begin
                            result_reg.status <= ST_WB_FAIL;
                        end
                        else if (cur_reg.fill_fails)
                        begin
                            dirty_reg[ent_reg] <= 1'b0;
                            result_reg.fill_issued <= 1'b1;
                            result_reg.status <= ST_FILL_FAIL;
                        end
                        else
                        begin
                            valid_reg[ent_reg] <= 1'b1;
                            dirty_reg[ent_reg] <= (cur_reg.req_type == REQ_WRITE);
                            clock_reg <= clock_reg + 32'd1;
                            result_reg.fill_issued <= 1'b1;
                            if (evict_reg != CNT_MAX)
                            begin
                                evict_reg <= evict_reg + 32'd1;
                                result_reg.evict_count <= evict_reg + 32'd1;
                            end
                        end
                    end
                end
                BE_FLUSH:
                begin
                    if (rd_ok_reg && vd[rd_idx_reg])
                    begin
                        strobe_reg <= 1'b1;
                        result_reg.slot      <= SLOT_W'(rd_idx_reg);
                        result_reg.wb_issued <= 1'b1;
                        result_reg.wb_addr   <= tag_rd_reg;
                        result_reg.status    <= (fst_reg || cur_reg.wb_fails)
                                                ? ST_WB_FAIL : ST_OK;
                        result_reg.last      <= !more_above;
                        if (!cur_reg.wb_fails)
                        begin
                            dirty_reg[rd_idx_reg] <= 1'b0;
                        end
                    end
                    else if (pend_last && !any_reg)
                    begin
                        strobe_reg <= 1'b1;
                        result_reg.last <= 1'b1;
                    end
                    result_reg.hit_count   <= hits_reg;
                    result_reg.miss_count  <= misses_reg;
                    result_reg.evict_count <= evict_reg;
                    result_reg.wb_count    <= wbs_reg;
                end
                BE_DONE:
                begin
                    strobe_reg <= 1'b1;
                    result_reg.last        <= 1'b1;
                    result_reg.hit_count   <= hits_reg;
                    result_reg.miss_count  <= misses_reg;
                    result_reg.evict_count <= evict_reg;
                    result_reg.wb_count    <= wbs_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    `LWSC_ASSERT_NEXT(a_hit_no_fill, clk, rst_n, state_reg == BE_ACCESS && found_reg, !result_reg.fill_issued && !result_reg.wb_issued, "hit word issued device traffic")
    `LWSC_ASSERT_IMP(a_take_idle, clk, rst_n, take, state_reg == BE_IDLE, "request taken while busy")
    `LWSC_ASSERT_NEXT(a_evict_sat, clk, rst_n, evict_reg == CNT_MAX, evict_reg == CNT_MAX, "eviction count wrapped")

endmodule

`default_nettype wire

// File: rtl/lru_writeback_sector_cache.sv
//------------------------------------------------------------------------------
// lru_writeback_sector_cache
// Tag and replacement controller for a fully associative write-back cache.
//------------------------------------------------------------------------------
// Usage: drive req with start high; the word is taken on an edge where busy
// is low. The front holds up to two requests; busy rises when it is full.
// Results come on rsp, one cycle each, marked by done; the last word of a
// request has rsp.last set. The receiver cannot stall, so nothing waits.
// A read or write sweeps every entry through the tag and age stores, one
// entry per cycle, and answers with one word after the sweep.
// A flush sweeps the same way and emits one word per dirty entry as the
// sweep passes it, in index order, or one bare last word if none is dirty.
// Throughput is one request per sweep; the single-entry read port of the
// tag and age stores sets that figure.
// Reset clears all valid and dirty bits, the access clock and the counters
// at once; no clearing pass is needed.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lru_writeback_sector_cache #(
    parameter int unsigned NUM_ENTRIES = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire lwsc_pkg::req_t req,
    output logic                busy,
    output logic                done,
    output lwsc_pkg::rsp_t      rsp
);
    import lwsc_pkg::*;

    logic full, empty, take;
    req_t head;

    lwsc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (start && !full),
        .push_data (req),
        .full      (full),
        .empty     (empty),
        .pop       (take),
        .head      (head)
    );

    lwsc_back #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .avail  (!empty),
        .req    (head),
        .take   (take),
        .strobe (done),
        .result (rsp)
    );

    assign busy = full;

endmodule

`default_nettype wire
